### sv/mnts_pkg.sv
// Shared types, codes, constants and the pitch table of the note tracker.
package mnts_pkg;

  // Default sizes.
  localparam int NOTE_SLOTS_DEF = 64;
  localparam int KEY_COUNT_DEF  = 128;

  // Field widths.
  localparam int TW     = 40;
  localparam int NW     = 7;
  localparam int SUSW   = 13;
  localparam int BASE_W = 21;
  localparam int DVD_W  = 21;
  localparam int AGE_W  = 16;

  // Sustain scaling: base_q8 * (127 + v) / (254 * 256).
  localparam int          VEL_OFS   = 127;
  localparam logic [63:0] EXP_STEP  = 64'd4143098513;
  localparam logic [63:0] BASE_MAXQ = 64'd2048000;
  localparam int          LOW_KEY   = 21;

  // Division by 254 as a halving followed by a multiply with ceil(2^27 / 127);
  // exact for every halved dividend below 2^20.
  localparam int                 RECIP_W   = 21;
  localparam logic [RECIP_W-1:0] SUS_RECIP = 21'd1056833;
  localparam int                 SUS_SHIFT = 27;

  // Reset values of the registers.
  localparam logic [AGE_W-1:0] AGE_RST = 16'd5000;
  localparam logic [NW-1:0]    THR_RST = 7'd63;
  localparam logic [NW-1:0]    CTL_RST = 7'd64;

  // Register indexes.
  localparam logic [1:0] CFG_AGE = 2'd0;
  localparam logic [1:0] CFG_THR = 2'd1;
  localparam logic [1:0] CFG_CTL = 2'd2;

  // Event kinds.
  localparam logic [1:0] K_ON   = 2'd0;
  localparam logic [1:0] K_OFF  = 2'd1;
  localparam logic [1:0] K_CTL  = 2'd2;
  localparam logic [1:0] K_TICK = 2'd3;

  // Report codes.
  localparam logic [2:0] REP_ADDED    = 3'd0;
  localparam logic [2:0] REP_RELEASED = 3'd1;
  localparam logic [2:0] REP_CUT      = 3'd2;
  localparam logic [2:0] REP_RETIRED  = 3'd3;
  localparam logic [2:0] REP_PEDAL    = 3'd4;
  localparam logic [2:0] REP_NOCHG    = 3'd5;
  localparam logic [2:0] REP_FULL     = 3'd6;

  // Ring read address select.
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_MAP  = 2'd1;
  localparam logic [1:0] RD_SCAN = 2'd2;
  localparam logic [1:0] RD_HEAD = 2'd3;

  // Ring write select.
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_ON   = 2'd1;
  localparam logic [1:0] WR_OFF  = 2'd2;
  localparam logic [1:0] WR_CUT  = 2'd3;

  // Hold register load select.
  localparam logic [1:0] H_NONE  = 2'd0;
  localparam logic [1:0] H_EVENT = 2'd1;
  localparam logic [1:0] H_REC   = 2'd2;

  typedef struct packed {
    logic [TW-1:0]   start_ms;
    logic [TW-1:0]   end_ms;
    logic [NW-1:0]   note;
    logic [NW-1:0]   vel;
    logic            open;
    logic [SUSW-1:0] sus;
    logic            sust;
  } rec_t;

  typedef struct packed {
    logic [2:0]      report;
    logic [5:0]      slot;
    logic [NW-1:0]   note;
    logic [NW-1:0]   vel;
    logic [TW-1:0]   start_ms;
    logic [TW-1:0]   end_ms;
    logic            end_open;
    logic [SUSW-1:0] sus;
    logic            sust;
  } res_t;

  typedef struct packed {
    logic       item_ld;
    logic       map_rd;
    logic [1:0] rd_sel;
    logic [1:0] wr_sel;
    logic       pedal_ld;
    logic       scan_clr;
    logic       scan_inc;
    logic       ret_adv;
    logic       div_start;
    logic [1:0] hold_sel;
    logic [2:0] hold_rep;
    logic       push;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       map_hit;
    logic       full;
    logic       ctl_match;
    logic       ped_new;
    logic       pedal;
    logic       scan_end;
    logic       count_zero;
    logic       cut_hit;
    logic       ret_hit;
    logic       div_done;
    logic       hold_vld;
    logic       out_free;
  } sts_t;

  // Pitch base in ms with 8 fraction bits, one entry per key; keys below
  // the lowest piano key share its value.
  typedef logic [BASE_W-1:0] base_tab_t [128];

  function automatic base_tab_t base_tab_f();
    base_tab_t   tab;
    logic [63:0] p;
    logic [63:0] prod;
    p = 64'd1 << 32;
    for (int n = 0; n < 128; n++) begin
      if (n > LOW_KEY) begin
        prod = p * EXP_STEP;
        p    = prod >> 32;
      end
      prod   = BASE_MAXQ * p;
      tab[n] = BASE_W'(prod >> 32);
    end
    return tab;
  endfunction

  localparam base_tab_t BASE_TAB = base_tab_f();

endpackage

### sv/mnts_div.sv
// Division of the scaled pitch base by 254 through a reciprocal multiply.
module mnts_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mnts_pkg::DVD_W-1:0]  dividend,
  output logic                        done,
  output logic [mnts_pkg::SUSW-1:0]   quot
);

  localparam int HALF_W = mnts_pkg::DVD_W - 1;
  localparam int PROD_W = HALF_W + mnts_pkg::RECIP_W;

  logic                     busy_r;
  logic                     done_r;
  logic [HALF_W-1:0]        num_r;
  logic [mnts_pkg::SUSW-1:0] q_r;
  logic [PROD_W-1:0]        prod;

  // Halved dividend times the reciprocal of 127.
  assign prod = PROD_W'(num_r) * PROD_W'(mnts_pkg::SUS_RECIP);

  // Start captures the operand, the next cycle forms the quotient.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  // Operand and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend[mnts_pkg::DVD_W-1:1];
    end
    if (busy_r) begin
      q_r <= mnts_pkg::SUSW'(prod >> mnts_pkg::SUS_SHIFT);
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### sv/mnts_ctrl.sv
// Sequencer of the note tracker: decodes each event and walks the ring.
module mnts_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mnts_pkg::sts_t       sts,
  output mnts_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_MAP      = 4'd2;
  localparam logic [3:0] S_REC      = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CHK = 4'd6;
  localparam logic [3:0] S_RET_RD   = 4'd7;
  localparam logic [3:0] S_RET_CHK  = 4'd8;
  localparam logic [3:0] S_END      = 4'd9;
  localparam logic [3:0] S_FLUSH    = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       push_ok;

  // A new result may enter the hold stage once the older one can move on.
  assign push_ok  = !sts.hold_vld || sts.out_free;
  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.kind)
          mnts_pkg::K_ON: begin
            state_nxt = S_FLUSH;
            if (sts.map_hit) begin
              cmd.hold_sel = mnts_pkg::H_EVENT;
              cmd.hold_rep = mnts_pkg::REP_NOCHG;
            end else if (sts.full) begin
              cmd.hold_sel = mnts_pkg::H_EVENT;
              cmd.hold_rep = mnts_pkg::REP_FULL;
            end else begin
              cmd.wr_sel   = mnts_pkg::WR_ON;
              cmd.hold_sel = mnts_pkg::H_REC;
              cmd.hold_rep = mnts_pkg::REP_ADDED;
            end
          end
          mnts_pkg::K_OFF: begin
            if (sts.map_hit) begin
              cmd.map_rd = 1'b1;
              state_nxt  = S_MAP;
            end else begin
              cmd.hold_sel = mnts_pkg::H_EVENT;
              cmd.hold_rep = mnts_pkg::REP_NOCHG;
              state_nxt    = S_FLUSH;
            end
          end
          mnts_pkg::K_CTL: begin
            if (!sts.ctl_match) begin
              cmd.hold_sel = mnts_pkg::H_EVENT;
              cmd.hold_rep = mnts_pkg::REP_NOCHG;
              state_nxt    = S_FLUSH;
            end else if (sts.ped_new) begin
              cmd.pedal_ld = 1'b1;
              cmd.hold_sel = mnts_pkg::H_EVENT;
              cmd.hold_rep = mnts_pkg::REP_PEDAL;
              state_nxt    = S_FLUSH;
            end else begin
              cmd.pedal_ld = 1'b1;
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN_RD;
            end
          end
          mnts_pkg::K_TICK: state_nxt = S_RET_RD;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MAP: begin
        cmd.rd_sel = mnts_pkg::RD_MAP;
        state_nxt  = S_REC;
      end
      S_REC: begin
        if (sts.pedal) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.wr_sel   = mnts_pkg::WR_OFF;
          cmd.hold_sel = mnts_pkg::H_REC;
          cmd.hold_rep = mnts_pkg::REP_RELEASED;
          state_nxt    = S_FLUSH;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.wr_sel   = mnts_pkg::WR_OFF;
          cmd.hold_sel = mnts_pkg::H_REC;
          cmd.hold_rep = mnts_pkg::REP_RELEASED;
          state_nxt    = S_FLUSH;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          state_nxt = S_END;
        end else begin
          cmd.rd_sel = mnts_pkg::RD_SCAN;
          state_nxt  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!sts.cut_hit) begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_SCAN_RD;
        end else if (push_ok) begin
          cmd.push     = sts.hold_vld;
          cmd.wr_sel   = mnts_pkg::WR_CUT;
          cmd.hold_sel = mnts_pkg::H_REC;
          cmd.hold_rep = mnts_pkg::REP_CUT;
          cmd.scan_inc = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_RET_RD: begin
        if (sts.count_zero) begin
          state_nxt = S_END;
        end else begin
          cmd.rd_sel = mnts_pkg::RD_HEAD;
          state_nxt  = S_RET_CHK;
        end
      end
      S_RET_CHK: begin
        if (!sts.ret_hit) begin
          state_nxt = S_END;
        end else if (push_ok) begin
          cmd.push     = sts.hold_vld;
          cmd.hold_sel = mnts_pkg::H_REC;
          cmd.hold_rep = mnts_pkg::REP_RETIRED;
          cmd.ret_adv  = 1'b1;
          state_nxt    = S_RET_RD;
        end
      end
      S_END: begin
        // An event that reported no record still gives one result.
        if (!sts.hold_vld) begin
          cmd.hold_sel = mnts_pkg::H_EVENT;
          cmd.hold_rep = (sts.kind == mnts_pkg::K_CTL) ? mnts_pkg::REP_PEDAL
                                                       : mnts_pkg::REP_NOCHG;
        end
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/mnts_dp.sv
// Datapath of the note tracker: ring memory, key map, pointers and result stages.
module mnts_dp #(
  parameter int NOTE_SLOTS = mnts_pkg::NOTE_SLOTS_DEF,
  parameter int KEY_COUNT  = mnts_pkg::KEY_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mnts_pkg::cmd_t               cmd,
  output mnts_pkg::sts_t               sts,
  input  logic [1:0]                   in_kind,
  input  logic [mnts_pkg::NW-1:0]      in_key,
  input  logic [mnts_pkg::NW-1:0]      in_value,
  input  logic [mnts_pkg::TW-1:0]      in_time_ms,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [mnts_pkg::AGE_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mnts_pkg::res_t               out_res,
  output logic                         out_last
);

  localparam int SW = $clog2(NOTE_SLOTS);
  localparam int CW = $clog2(NOTE_SLOTS + 1);
  localparam int KW = $clog2(KEY_COUNT);
  localparam logic [SW:0]   SLOTS_S = (SW + 1)'(NOTE_SLOTS);
  localparam logic [CW-1:0] SLOTS_C = CW'(NOTE_SLOTS);

  // Configuration registers.
  logic [mnts_pkg::AGE_W-1:0] age_r;
  logic [mnts_pkg::NW-1:0]    thr_r;
  logic [mnts_pkg::NW-1:0]    ctl_r;

  // Latched input beat.
  logic [1:0]              kind_r;
  logic [mnts_pkg::NW-1:0] key_r;
  logic [mnts_pkg::NW-1:0] val_r;
  logic [mnts_pkg::TW-1:0] t_r;

  // Ring state.
  mnts_pkg::rec_t  ring_mem [NOTE_SLOTS];
  mnts_pkg::rec_t  ring_q_r;
  logic [SW-1:0]   head_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   scan_r;
  logic [SW-1:0]   slot_r;
  logic            pedal_r;

  // Key map.
  logic [SW-1:0]        map_mem [KEY_COUNT];
  logic [SW-1:0]        map_q_r;
  logic [KEY_COUNT-1:0] map_vld_r;
  logic [KW-1:0]        key_idx;

  // Result stages.
  mnts_pkg::res_t hold_r;
  logic           hold_vld_r;
  mnts_pkg::res_t out_r;
  logic           out_vld_r;
  logic           out_last_r;

  // Address and record logic.
  logic [SW:0]        tail_sum;
  logic [SW-1:0]      tail_slot;
  logic [SW:0]        scan_sum;
  logic [SW-1:0]      scan_slot;
  logic [SW-1:0]      head_inc;
  logic [SW-1:0]      rd_addr;
  logic [SW-1:0]      wr_addr;
  mnts_pkg::rec_t     wr_rec;
  mnts_pkg::rec_t     src_rec;
  logic [SW-1:0]      src_slot;
  mnts_pkg::res_t     rec_res;
  mnts_pkg::res_t     evt_res;
  logic [mnts_pkg::TW:0] cut_lim;
  logic [mnts_pkg::TW:0] ret_lim;
  logic                  out_free;

  // Sustain computation.
  logic [mnts_pkg::BASE_W-1:0]  base_q8;
  logic [7:0]                   vel_ofs;
  logic [mnts_pkg::BASE_W+7:0]  sus_prod;
  logic [mnts_pkg::DVD_W-1:0]   dvd;
  logic                         div_done;
  logic [mnts_pkg::SUSW-1:0]    div_q;

  assign cfg_ready = 1'b1;
  assign key_idx   = KW'(key_r);

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= mnts_pkg::AGE_RST;
      thr_r <= mnts_pkg::THR_RST;
      ctl_r <= mnts_pkg::CTL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mnts_pkg::CFG_AGE: age_r <= cfg_data;
        mnts_pkg::CFG_THR: thr_r <= cfg_data[mnts_pkg::NW-1:0];
        mnts_pkg::CFG_CTL: ctl_r <= cfg_data[mnts_pkg::NW-1:0];
        default: ;
      endcase
    end
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      val_r  <= in_value;
      t_r    <= in_time_ms;
    end
  end

  // Slot arithmetic with wrap at the ring size.
  assign tail_sum  = (SW + 1)'(head_r) + (SW + 1)'(count_r);
  assign tail_slot = (tail_sum >= SLOTS_S) ? SW'(tail_sum - SLOTS_S) : SW'(tail_sum);
  assign scan_sum  = (SW + 1)'(head_r) + (SW + 1)'(scan_r);
  assign scan_slot = (scan_sum >= SLOTS_S) ? SW'(scan_sum - SLOTS_S) : SW'(scan_sum);
  assign head_inc  = ((SW + 1)'(head_r) + 1'b1 == SLOTS_S) ? '0 : SW'(head_r + 1'b1);

  always_comb begin
    unique case (cmd.rd_sel)
      mnts_pkg::RD_MAP:  rd_addr = map_q_r;
      mnts_pkg::RD_SCAN: rd_addr = scan_slot;
      mnts_pkg::RD_HEAD: rd_addr = head_r;
      default:           rd_addr = slot_r;
    endcase
  end

  // Record to be written for each kind of update.
  always_comb begin
    wr_rec  = ring_q_r;
    wr_addr = slot_r;
    unique case (cmd.wr_sel)
      mnts_pkg::WR_ON: begin
        wr_addr         = tail_slot;
        wr_rec.start_ms = t_r;
        wr_rec.end_ms   = '0;
        wr_rec.note     = key_r;
        wr_rec.vel      = val_r;
        wr_rec.open     = 1'b1;
        wr_rec.sus      = '0;
        wr_rec.sust     = 1'b0;
      end
      mnts_pkg::WR_OFF: begin
        wr_rec.end_ms = t_r;
        wr_rec.open   = 1'b0;
        wr_rec.sus    = pedal_r ? div_q : '0;
        wr_rec.sust   = pedal_r;
      end
      mnts_pkg::WR_CUT: begin
        wr_rec.end_ms = t_r;
        wr_rec.sust   = 1'b0;
      end
      default: ;
    endcase
  end

  // Ring memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_sel != mnts_pkg::WR_NONE) begin
      ring_mem[wr_addr] <= wr_rec;
    end
    if (cmd.rd_sel != mnts_pkg::RD_NONE) begin
      ring_q_r <= ring_mem[rd_addr];
      slot_r   <= rd_addr;
    end
  end

  // Key map slots, registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_sel == mnts_pkg::WR_ON) begin
      map_mem[key_idx] <= tail_slot;
    end
    if (cmd.map_rd) begin
      map_q_r <= map_mem[key_idx];
    end
  end

  // Ring pointers, scan index, key valid bits and pedal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      scan_r    <= '0;
      map_vld_r <= '0;
      pedal_r   <= 1'b0;
    end else begin
      if (cmd.wr_sel == mnts_pkg::WR_ON) begin
        count_r            <= count_r + 1'b1;
        map_vld_r[key_idx] <= 1'b1;
      end else if (cmd.ret_adv) begin
        count_r <= count_r - 1'b1;
        head_r  <= head_inc;
      end
      if (cmd.wr_sel == mnts_pkg::WR_OFF) begin
        map_vld_r[key_idx] <= 1'b0;
      end
      if (cmd.scan_clr) begin
        scan_r <= '0;
      end else if (cmd.scan_inc) begin
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.pedal_ld) begin
        pedal_r <= (val_r > thr_r);
      end
    end
  end

  // Scaled pitch base feeds the divider.
  assign base_q8  = mnts_pkg::BASE_TAB[ring_q_r.note];
  assign vel_ofs  = 8'(mnts_pkg::VEL_OFS) + 8'(ring_q_r.vel);
  assign sus_prod = (mnts_pkg::BASE_W + 8)'(base_q8) * (mnts_pkg::BASE_W + 8)'(vel_ofs);
  assign dvd      = mnts_pkg::DVD_W'(sus_prod >> 8);

  mnts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .done     (div_done),
    .quot     (div_q)
  );

  // Result from a record: the one just written, or the one just read.
  assign src_rec  = (cmd.wr_sel == mnts_pkg::WR_NONE) ? ring_q_r : wr_rec;
  assign src_slot = (cmd.wr_sel == mnts_pkg::WR_NONE) ? slot_r : wr_addr;

  always_comb begin
    rec_res.report   = cmd.hold_rep;
    rec_res.slot     = 6'(src_slot);
    rec_res.note     = src_rec.note;
    rec_res.vel      = src_rec.vel;
    rec_res.start_ms = src_rec.start_ms;
    rec_res.end_ms   = src_rec.open ? '0 : src_rec.end_ms;
    rec_res.end_open = src_rec.open;
    rec_res.sus      = src_rec.sus;
    rec_res.sust     = src_rec.sust;
  end

  // Result that describes the event itself.
  always_comb begin
    evt_res.report   = cmd.hold_rep;
    evt_res.slot     = '0;
    evt_res.note     = key_r;
    evt_res.vel      = val_r;
    evt_res.start_ms = t_r;
    evt_res.end_ms   = '0;
    evt_res.end_open = 1'b0;
    evt_res.sus      = '0;
    evt_res.sust     = (cmd.hold_rep == mnts_pkg::REP_PEDAL) && (val_r > thr_r);
  end

  // Hold stage keeps one result until it is known whether it is the last.
  assign out_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (cmd.hold_sel != mnts_pkg::H_NONE) begin
      hold_vld_r <= 1'b1;
    end else if (cmd.flush) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_sel == mnts_pkg::H_EVENT) begin
      hold_r <= evt_res;
    end else if (cmd.hold_sel == mnts_pkg::H_REC) begin
      hold_r <= rec_res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.push || cmd.flush) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.flush) begin
      out_r      <= hold_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

  // Status for the sequencer.
  assign cut_lim = (mnts_pkg::TW + 1)'(ring_q_r.start_ms) + (mnts_pkg::TW + 1)'(ring_q_r.sus);
  assign ret_lim = (mnts_pkg::TW + 1)'(ring_q_r.end_ms) + (mnts_pkg::TW + 1)'(age_r);

  always_comb begin
    sts.kind       = kind_r;
    sts.map_hit    = map_vld_r[key_idx];
    sts.full       = (count_r == SLOTS_C);
    sts.ctl_match  = (key_r == ctl_r);
    sts.ped_new    = (val_r > thr_r);
    sts.pedal      = pedal_r;
    sts.scan_end   = (scan_r >= count_r);
    sts.count_zero = (count_r == '0);
    sts.cut_hit    = ring_q_r.sust && ((mnts_pkg::TW + 1)'(t_r) < cut_lim);
    sts.ret_hit    = !ring_q_r.open && (ret_lim <= (mnts_pkg::TW + 1)'(t_r));
    sts.div_done   = div_done;
    sts.hold_vld   = hold_vld_r;
    sts.out_free   = out_free;
  end

  // Checks on the ring and the result stages.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SLOTS_C)
    else $error("ring count exceeds the slot count");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push || cmd.flush) |-> (!out_vld_r || out_ready))
    else $error("output register overwritten while a beat waits");

  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push || cmd.flush) |-> hold_vld_r)
    else $error("empty hold stage moved to the output");

  a_no_add_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_sel == mnts_pkg::WR_ON) |-> (count_r != SLOTS_C))
    else $error("record appended to a full ring");

endmodule

### sv/midi_note_tracker_sustain.sv
// Events decoded at once go straight to the flush; a note-off first reads the key map and
// its record, and with the pedal down also waits on the reciprocal multiply.
// Pedal release and tick walk the ring, a read and a check per slot, for at most NOTE_SLOTS
// slots; every event may also wait on the result channel.
// One item at a time: in_ready returns the cycle after the last result is registered.
// Reset clears pointers, key valid bits, pedal and registers; ring memory is not swept.
module midi_note_tracker_sustain #(
  parameter int NOTE_SLOTS = mnts_pkg::NOTE_SLOTS_DEF,
  parameter int KEY_COUNT  = mnts_pkg::KEY_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [mnts_pkg::NW-1:0]     in_key,
  input  logic [mnts_pkg::NW-1:0]     in_value,
  input  logic [mnts_pkg::TW-1:0]     in_time_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_report,
  output logic [5:0]                  out_slot,
  output logic [mnts_pkg::NW-1:0]     out_note_number,
  output logic [mnts_pkg::NW-1:0]     out_velocity,
  output logic [mnts_pkg::TW-1:0]     out_start_ms,
  output logic [mnts_pkg::TW-1:0]     out_end_ms,
  output logic                        out_end_open,
  output logic [mnts_pkg::SUSW-1:0]   out_sustain_ms,
  output logic                        out_sustaining,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [mnts_pkg::AGE_W-1:0]  cfg_data
);

  mnts_pkg::cmd_t cmd;
  mnts_pkg::sts_t sts;
  mnts_pkg::res_t res;

  mnts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mnts_dp #(
    .NOTE_SLOTS (NOTE_SLOTS),
    .KEY_COUNT  (KEY_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_kind),
    .in_key     (in_key),
    .in_value   (in_value),
    .in_time_ms (in_time_ms),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res),
    .out_last   (out_last)
  );

  // Result fields onto their ports.
  assign out_report      = res.report;
  assign out_slot        = res.slot;
  assign out_note_number = res.note;
  assign out_velocity    = res.vel;
  assign out_start_ms    = res.start_ms;
  assign out_end_ms      = res.end_ms;
  assign out_end_open    = res.end_open;
  assign out_sustain_ms  = res.sus;
  assign out_sustaining  = res.sust;

endmodule

### bench/tb_top.sv
// Self-checking bench for the MIDI note tracker with sustain pedal.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic [1:0]  kind;
    logic [6:0]  key;
    logic [6:0]  val;
    logic [39:0] t;
  } note_evt_t;

  typedef struct {
    mnts_pkg::res_t r;
    bit             last;
  } note_res_t;

  localparam int SLOTS = 64;
  localparam int WATCH_LIMIT = 5000;
  localparam logic [63:0] SUS_STEP = 64'd4143098513;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_kind;
  logic [6:0] in_key, in_value;
  logic [39:0] in_time_ms;
  logic out_valid, out_ready;
  logic [2:0] out_report;
  logic [5:0] out_slot;
  logic [6:0] out_note_number, out_velocity;
  logic [39:0] out_start_ms, out_end_ms;
  logic out_end_open;
  logic [12:0] out_sustain_ms;
  logic out_sustaining, out_last;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  midi_note_tracker_sustain uut (.*);

  // Pending events, expected records and bookkeeping.
  note_evt_t pend_q[$];
  note_res_t want_q[$];
  note_res_t fresh_q[$];
  int events_queued = 0;
  int events_taken = 0;
  int fails = 0;
  bit calm = 0;
  logic [63:0] tnow;

  // Tracker image: note ring, key map, pedal and registers.
  logic [39:0] r_start[SLOTS];
  logic [39:0] r_end[SLOTS];
  logic [6:0]  r_note[SLOTS];
  logic [6:0]  r_vel[SLOTS];
  bit          r_open[SLOTS];
  logic [12:0] r_sus[SLOTS];
  bit          r_sust[SLOTS];
  int          ring_head, ring_count;
  bit          key_held[128];
  int          key_slot[128];
  bit          pedal;
  logic [15:0] age_reg;
  logic [6:0]  thr_reg, ctl_reg;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Ring-down time of a released key under the pedal.
  function automatic logic [12:0] ring_down_ms(logic [6:0] note, logic [6:0] vel);
    logic [63:0] p;
    logic [63:0] base;
    int n;
    p = 64'd1 << 32;
    n = (note < 21) ? 21 : note;
    for (int i = 21; i < n; i++) p = (p * SUS_STEP) >> 32;
    base = (64'd2048000 * p) >> 32;
    return 13'((base * (64'd127 + vel)) / 64'd65024);
  endfunction

  function automatic void emit(logic [2:0] rep, int s, logic [6:0] note, logic [6:0] vel,
                               logic [39:0] st, logic [39:0] en, bit op,
                               logic [12:0] sus, bit sust);
    note_res_t e;
    e.r.report = rep;
    e.r.slot = 6'(s);
    e.r.note = note;
    e.r.vel = vel;
    e.r.start_ms = st;
    e.r.end_ms = en;
    e.r.end_open = op;
    e.r.sus = sus;
    e.r.sust = sust;
    e.last = 0;
    fresh_q.push_back(e);
  endfunction

  function automatic void emit_rec(logic [2:0] rep, int s);
    emit(rep, s, r_note[s], r_vel[s], r_start[s], r_open[s] ? 40'd0 : r_end[s],
         r_open[s], r_sus[s], r_sust[s]);
  endfunction

  // Apply one event to the image and queue the records it reports.
  function automatic void track_event(note_evt_t ev);
    int s;
    fresh_q.delete();
    case (ev.kind)
      mnts_pkg::K_ON: begin
        if (!key_held[ev.key]) begin
          if (ring_count >= SLOTS) begin
            emit(mnts_pkg::REP_FULL, 0, ev.key, ev.val, ev.t, 0, 0, 0, 0);
          end else begin
            s = (ring_head + ring_count) % SLOTS;
            ring_count++;
            r_start[s] = ev.t;
            r_end[s] = 0;
            r_note[s] = ev.key;
            r_vel[s] = ev.val;
            r_open[s] = 1;
            r_sus[s] = 0;
            r_sust[s] = 0;
            key_held[ev.key] = 1;
            key_slot[ev.key] = s;
            emit_rec(mnts_pkg::REP_ADDED, s);
          end
        end else begin
          emit(mnts_pkg::REP_NOCHG, 0, ev.key, ev.val, ev.t, 0, 0, 0, 0);
        end
      end
      mnts_pkg::K_OFF: begin
        if (key_held[ev.key]) begin
          s = key_slot[ev.key];
          r_end[s] = ev.t;
          r_open[s] = 0;
          r_sus[s] = pedal ? ring_down_ms(r_note[s], r_vel[s]) : 13'd0;
          r_sust[s] = pedal;
          key_held[ev.key] = 0;
          emit_rec(mnts_pkg::REP_RELEASED, s);
        end else begin
          emit(mnts_pkg::REP_NOCHG, 0, ev.key, ev.val, ev.t, 0, 0, 0, 0);
        end
      end
      mnts_pkg::K_CTL: begin
        if (ev.key == ctl_reg) begin
          pedal = ev.val > thr_reg;
          if (!pedal) begin
            for (int i = 0; i < ring_count; i++) begin
              s = (ring_head + i) % SLOTS;
              if (r_sust[s] && ({24'd0, ev.t} < {24'd0, r_start[s]} + r_sus[s])) begin
                r_end[s] = ev.t;
                r_sust[s] = 0;
                emit_rec(mnts_pkg::REP_CUT, s);
              end
            end
          end
          if (fresh_q.size() == 0)
            emit(mnts_pkg::REP_PEDAL, 0, ev.key, ev.val, ev.t, 0, 0, 0, pedal);
        end else begin
          emit(mnts_pkg::REP_NOCHG, 0, ev.key, ev.val, ev.t, 0, 0, 0, 0);
        end
      end
      default: begin
        while (ring_count > 0) begin
          s = ring_head;
          if (r_open[s] || ({24'd0, r_end[s]} + age_reg > {24'd0, ev.t})) break;
          emit_rec(mnts_pkg::REP_RETIRED, s);
          ring_head = (s + 1) % SLOTS;
          ring_count--;
        end
        if (fresh_q.size() == 0)
          emit(mnts_pkg::REP_NOCHG, 0, ev.key, ev.val, ev.t, 0, 0, 0, 0);
      end
    endcase
    fresh_q[fresh_q.size() - 1].last = 1;
    foreach (fresh_q[i]) want_q.push_back(fresh_q[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void queue_evt(logic [1:0] kind, logic [6:0] key, logic [6:0] val,
                                    logic [39:0] t);
    note_evt_t ev;
    ev.kind = kind;
    ev.key = key;
    ev.val = val;
    ev.t = t;
    pend_q.push_back(ev);
    events_queued++;
  endfunction

  // One random event, mostly musical with a little noise.
  function automatic void queue_random();
    int r;
    logic [1:0] kind;
    logic [6:0] key;
    logic [39:0] t;
    r = $urandom_range(0, 99);
    kind = (r < 35) ? mnts_pkg::K_ON : (r < 65) ? mnts_pkg::K_OFF :
           (r < 82) ? mnts_pkg::K_CTL : mnts_pkg::K_TICK;
    if (kind == mnts_pkg::K_CTL) key = ($urandom_range(0, 99) < 80) ? ctl_reg : 7'($urandom);
    else key = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(15, 40)) : 7'($urandom);
    tnow += $urandom_range(0, 400);
    t = ($urandom_range(0, 99) < 4) ? {8'($urandom), 32'($urandom)} : tnow[39:0];
    queue_evt(kind, key, 7'($urandom), t);
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == mnts_pkg::CFG_AGE) age_reg = data;
    else if (idx == mnts_pkg::CFG_THR) thr_reg = data[6:0];
    else if (idx == mnts_pkg::CFG_CTL) ctl_reg = data[6:0];
    cfg_valid <= 0;
  endtask

  // Wait for every event and record to pass, then let the block settle.
  task automatic drain();
    do @(posedge clk); while (events_taken != events_queued || want_q.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  // Input driver.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) begin
        track_event('{in_kind, in_key, in_value, in_time_ms});
        events_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (pend_q.size() > 0) begin
          note_evt_t ev;
          ev = pend_q.pop_front();
          in_kind <= ev.kind;
          in_key <= ev.key;
          in_value <= ev.val;
          in_time_ms <= ev.t;
          in_valid <= 1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // Result monitor with random back-pressure.
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $error("unexpected record: report %0d slot %0d", out_report, out_slot);
          fails++;
        end else begin
          note_res_t e;
          e = want_q.pop_front();
          check_field("report", e.r.report, out_report);
          check_field("slot", e.r.slot, out_slot);
          check_field("note_number", e.r.note, out_note_number);
          check_field("velocity", e.r.vel, out_velocity);
          check_field("start_ms", e.r.start_ms, out_start_ms);
          check_field("end_ms", e.r.end_ms, out_end_ms);
          check_field("end_open", e.r.end_open, out_end_open);
          check_field("sustain_ms", e.r.sus, out_sustain_ms);
          check_field("sustaining", e.r.sust, out_sustaining);
          check_field("last", e.last, out_last);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if ($urandom_range(0, 99) < 30) out_gap = pick_gap();
      end
    end
  end

  // Watchdog on cycles with no beat on any channel.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("midi_note_tracker_sustain verification failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    rst_n = 0;
    in_valid = 0;
    in_kind = 0;
    in_key = 0;
    in_value = 0;
    in_time_ms = 0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    ring_head = 0;
    ring_count = 0;
    pedal = 0;
    age_reg = mnts_pkg::AGE_RST;
    thr_reg = mnts_pkg::THR_RST;
    ctl_reg = mnts_pkg::CTL_RST;
    foreach (key_held[i]) key_held[i] = 0;
    tnow = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    repeat (3) @(posedge clk);

    // Directed events at reset settings: extremes, sustain, cut and retire.
    queue_evt(mnts_pkg::K_ON, 0, 0, 0);
    queue_evt(mnts_pkg::K_ON, 127, 127, 1);
    queue_evt(mnts_pkg::K_ON, 0, 5, 2);
    queue_evt(mnts_pkg::K_OFF, 5, 9, 3);
    queue_evt(mnts_pkg::K_CTL, 64, 127, 4);
    queue_evt(mnts_pkg::K_OFF, 0, 1, 10);
    queue_evt(mnts_pkg::K_OFF, 127, 2, 20);
    queue_evt(mnts_pkg::K_CTL, 10, 5, 25);
    queue_evt(mnts_pkg::K_CTL, 64, 0, 30);
    queue_evt(mnts_pkg::K_CTL, 64, 63, 31);
    queue_evt(mnts_pkg::K_TICK, 0, 0, 100);
    queue_evt(mnts_pkg::K_TICK, 127, 127, 40'hFF_FFFF_FFFF);
    queue_evt(mnts_pkg::K_ON, 60, 127, 40'hFF_FFFF_FFFF);
    queue_evt(mnts_pkg::K_OFF, 60, 0, 100);
    queue_evt(mnts_pkg::K_TICK, 1, 1, 6000);
    queue_evt(mnts_pkg::K_CTL, 64, 64, 6100);
    queue_evt(mnts_pkg::K_ON, 21, 64, 6200);
    queue_evt(mnts_pkg::K_OFF, 21, 64, 6300);
    queue_evt(mnts_pkg::K_CTL, 64, 10, 6400);
    tnow = 7000;
    drain();

    // Fill the ring past capacity, release everything, retire it all.
    calm = 1;
    for (int k = 0; k < 70; k++)
      queue_evt(mnts_pkg::K_ON, 7'(k), 7'($urandom), 40'(tnow + k));
    for (int k = 0; k < 70; k++) queue_evt(mnts_pkg::K_OFF, 7'(k), 0, 40'(tnow + 100 + k));
    tnow += 80000;
    queue_evt(mnts_pkg::K_TICK, 0, 0, tnow[39:0]);
    drain();
    calm = 0;

    // Random phases across register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(mnts_pkg::CFG_AGE, 16'd0);
          reg_write(mnts_pkg::CFG_THR, 16'd0);
          reg_write(mnts_pkg::CFG_CTL, 16'd0);
        end
        1: begin
          reg_write(mnts_pkg::CFG_AGE, 16'hFFFF);
          reg_write(mnts_pkg::CFG_THR, 16'hFFFF);
          reg_write(mnts_pkg::CFG_CTL, 16'hFFFF);
        end
        2: begin
          reg_write(2'd3, 16'($urandom));
          reg_write(mnts_pkg::CFG_AGE, 16'd800);
          reg_write(mnts_pkg::CFG_THR, 16'd63);
          reg_write(mnts_pkg::CFG_CTL, 16'd64);
        end
        default: begin
          reg_write(mnts_pkg::CFG_AGE, 16'($urandom_range(0, 6000)));
          reg_write(mnts_pkg::CFG_THR, 16'($urandom_range(20, 100)));
          reg_write(mnts_pkg::CFG_CTL, 16'($urandom));
        end
      endcase
      calm = (ph == 3);
      for (int k = 0; k < 18; k++) queue_random();
      tnow += 70000;
      queue_evt(mnts_pkg::K_TICK, 0, 0, tnow[39:0]);
      drain();
    end

    if (fails == 0) begin
      $display("midi_note_tracker_sustain verification clean");
    end else begin
      $display("midi_note_tracker_sustain verification failed");
    end
    $finish;
  end

endmodule
